// ===== design/pvma_pkg.sv =====
// Shared constants, types and helper functions of the moving-average
// velocity estimator. No dependencies.
package pvma_pkg;

  // Ring depth; the divide-by-depth helper below relies on a power of two.
  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);

  localparam int POS_W   = 32;
  localparam int VEL_W   = 32;
  localparam int SCALE_W = 20;
  localparam int DIFF_W  = POS_W + 1;
  localparam int PROD_W  = DIFF_W + SCALE_W + 1;

  localparam logic [SCALE_W-1:0] SCALE_RST = 20'd1000;

  // Action codes of an input transaction.
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // Front-to-back queue.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic                    action;
    logic signed [VEL_W-1:0] vel;
  } q_entry_t;

  // Queue handshake between front and back.
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  // Saturate the exact product to signed VEL_W bits.
  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [PROD_W-1:0] p);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &p[PROD_W-1:VEL_W-1];
    hi_zeros = ~|p[PROD_W-1:VEL_W-1];
    if (hi_ones || hi_zeros) begin
      return p[VEL_W-1:0];
    end else if (p[PROD_W-1]) begin
      return {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VEL_W-1){1'b1}}};
    end
  endfunction

  // Signed divide by DEPTH, truncating toward zero.
  function automatic logic signed [VEL_W-1:0] div_depth(input logic signed [VEL_W-1:0] x);
    logic signed [VEL_W:0] adj;
    logic signed [VEL_W:0] shf;
    adj = {x[VEL_W-1], x} + (x[VEL_W-1] ? (VEL_W+1)'(DEPTH - 1) : (VEL_W+1)'(0));
    shf = adj >>> IDX_W;
    return shf[VEL_W-1:0];
  endfunction

endpackage

// ===== design/pvma_ifs.sv =====
// Channel interfaces: input samples, result velocities and the scale write port.
// Depends on pvma_pkg for field widths.
interface pvma_in_if;
  import pvma_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic signed [POS_W-1:0] position;
  modport source (output valid, output action, output position, input ready);
  modport sink   (input valid, input action, input position, output ready);
endinterface

interface pvma_out_if;
  import pvma_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] velocity;
  modport source (output valid, output velocity, input ready);
  modport sink   (input valid, input velocity, output ready);
endinterface

interface pvma_cfg_if;
  import pvma_pkg::*;
  logic               valid;
  logic               ready;
  logic [SCALE_W-1:0] velocity_scale;
  modport source (output valid, output velocity_scale, input ready);
  modport sink   (input valid, input velocity_scale, output ready);
endinterface

// ===== design/pvma_front.sv =====
// Front end: accepts transactions, tracks the previous position, forms the
// scaled saturated velocity. Depends on pvma_pkg and pvma_ifs.
module pvma_front
  import pvma_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  pvma_in_if.sink    in_ch,
  pvma_cfg_if.sink   cfg_ch,
  output q_push_t    push,
  input  logic       push_ready
);

  logic signed [POS_W-1:0]  prev_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic                     act_r;
  logic                     f1_v_r;
  logic [SCALE_W-1:0]       scale_r;
  logic signed [PROD_W-1:0] prod;
  logic                     in_take;

  // Hold both channels off while in reset.
  assign cfg_ch.ready = rst_n;
  assign in_ch.ready  = rst_n && (!f1_v_r || push_ready);
  assign in_take      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      f1_v_r  <= 1'b0;
      scale_r <= SCALE_RST;
    end else begin
      if (cfg_ch.valid) begin
        scale_r <= cfg_ch.velocity_scale;
      end
      if (in_take) begin
        f1_v_r <= 1'b1;
        prev_r <= in_ch.position;
      end else if (push_ready) begin
        f1_v_r <= 1'b0;
      end
    end
  end

  // Exact 33-bit difference; a clear carries a don't-care difference.
  always_ff @(posedge clk) begin
    if (in_take) begin
      diff_r <= {in_ch.position[POS_W-1], in_ch.position} - {prev_r[POS_W-1], prev_r};
      act_r  <= in_ch.action;
    end
  end

  assign prod = diff_r * $signed({1'b0, scale_r});

  assign push.valid        = f1_v_r;
  assign push.entry.action = act_r;
  assign push.entry.vel    = sat_vel(prod);

`ifndef SYNTH
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    f1_v_r && !push_ready |=> f1_v_r && $stable(diff_r) && $stable(act_r))
    else $error("front stage dropped a stalled transaction");
`endif

endmodule

// ===== design/pvma_queue.sv =====
// Two-entry queue between front and back ends.
// Depends on pvma_pkg.
module pvma_queue
  import pvma_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  q_push_t  push,
  output logic     push_ready,
  output q_push_t  pop,
  input  logic     pop_ready
);

  q_entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop.valid  = (cnt_r != '0);
  assign pop.entry  = mem_r[rd_ptr_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop.valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count over depth");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count missed a push");
`endif

endmodule

// ===== design/pvma_back.sv =====
// Back end: ring of recent velocities, running average update and the
// output register. Depends on pvma_pkg and pvma_ifs.
module pvma_back
  import pvma_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  q_push_t    pop,
  output logic       pop_ready,
  pvma_out_if.source out_ch
);

  logic signed [VEL_W-1:0] ring_r [DEPTH];
  logic [DEPTH-1:0]        valid_r;
  logic [IDX_W-1:0]        idx_r;
  logic signed [VEL_W-1:0] avg_r;
  logic signed [VEL_W-1:0] avg_nxt;
  logic signed [VEL_W-1:0] old_vel;
  logic                    out_v_r;
  logic signed [VEL_W-1:0] out_data_r;
  logic                    take;
  logic                    is_clear;

  assign pop_ready = !out_v_r || out_ch.ready;
  assign take      = pop.valid && pop_ready;
  assign is_clear  = (pop.entry.action == ACT_CLEAR);

  // Empty slots read as zero.
  assign old_vel = valid_r[idx_r] ? ring_r[idx_r] : '0;

  always_comb begin
    if (is_clear) begin
      avg_nxt = '0;
    end else begin
      avg_nxt = avg_r - div_depth(old_vel) + div_depth(pop.entry.vel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      idx_r   <= '0;
      avg_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (take) begin
        if (is_clear) begin
          valid_r <= '0;
          idx_r   <= '0;
        end else begin
          valid_r[idx_r] <= 1'b1;
          idx_r          <= (idx_r == IDX_W'(DEPTH - 1)) ? '0 : idx_r + 1'b1;
        end
        avg_r   <= avg_nxt;
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !is_clear) begin
      ring_r[idx_r] <= pop.entry.vel;
    end
    if (take) begin
      out_data_r <= avg_nxt;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.velocity = out_data_r;

`ifndef SYNTH
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    take && is_clear |=> out_data_r == '0 && avg_r == '0 && valid_r == '0 && idx_r == '0)
    else $error("clear left ring state behind");
  a_slot_marked: assert property (@(posedge clk) disable iff (!rst_n)
    take && !is_clear |=> valid_r[$past(idx_r)])
    else $error("written slot not marked valid");
  a_out_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_data_r == avg_r)
    else $error("pending result differs from running average");
`endif

endmodule

// ===== design/position_velocity_moving_average_top.sv =====
// Boxcar moving-average velocity estimator, top level.
// Transactions pass through the front register, the queue and the output register; one transaction
// per cycle sustained through the front multiply stage and the ring update while out_ch is ready.
// Reset (rst_n low, synchronous): scale 1000, previous position, average,
// ring index and entry valid bits cleared; queue and output emptied.
module position_velocity_moving_average_top
  import pvma_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  pvma_in_if.sink     in_ch,
  pvma_cfg_if.sink    cfg_ch,
  pvma_out_if.source  out_ch
);

  q_push_t push;
  logic    push_ready;
  q_push_t pop;
  logic    pop_ready;

  pvma_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push       (push),
    .push_ready (push_ready)
  );

  pvma_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_ready  (pop_ready)
  );

  pvma_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop       (pop),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

// ===== tb/position_velocity_moving_average_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench of position_velocity_moving_average_top: directed table, then random samples
// and clears under several scale settings; averages checked against typed rows or a local estimator.
// Depends on pvma_pkg and the channel interfaces in pvma_ifs.
module position_velocity_moving_average_top_tb;
  import pvma_pkg::*;

  localparam int ROW_COUNT      = 23;
  localparam int PHASE_COUNT    = 7;
  localparam int PHASE_ITEMS    = 70;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic                    action;
    logic signed [POS_W-1:0] position;
    logic                    typed;
    logic signed [VEL_W-1:0] velocity;
  } stim_row_t;

  logic clk;
  logic rst_n;
  bit   no_idle;
  bit   mismatch_seen;
  int   stall_cycles;

  // Expected velocity of the row now on the input channel, when typed in the table
  logic                    row_typed;
  logic signed [VEL_W-1:0] row_velocity;

  // Estimator state
  logic [SCALE_W-1:0]      scale_est = SCALE_RST;
  logic signed [VEL_W-1:0] velocity_history [DEPTH];
  logic [IDX_W-1:0]        history_slot = '0;
  logic signed [POS_W-1:0] last_sample_pos = '0;
  logic signed [VEL_W-1:0] average_est = '0;

  logic signed [VEL_W-1:0] expected_velocities [$];
  logic signed [VEL_W-1:0] predicted_velocity;

  pvma_in_if  in_ch ();
  pvma_out_if out_ch ();
  pvma_cfg_if cfg_ch ();

  position_velocity_moving_average_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= no_idle || ($urandom_range(99) >= 16);
    end
  end

  function automatic logic signed [VEL_W-1:0] predict_average(input logic act,
                                                              input logic signed [POS_W-1:0] pos);
    longint product;
    longint sum;
    logic signed [VEL_W-1:0] velocity_now;
    if (act == ACT_CLEAR) begin
      for (int i = 0; i < DEPTH; i++) velocity_history[i] = '0;
      history_slot = '0;
      average_est = '0;
    end else begin
      product = (longint'(pos) - longint'(last_sample_pos)) * longint'(scale_est);
      if (product > 64'sd2147483647) begin
        velocity_now = {1'b0, {(VEL_W-1){1'b1}}};
      end else if (product < -64'sd2147483648) begin
        velocity_now = {1'b1, {(VEL_W-1){1'b0}}};
      end else begin
        velocity_now = product[VEL_W-1:0];
      end
      // Evict the oldest entry and add the newest, each truncated toward zero
      sum = longint'(average_est) - longint'(velocity_history[history_slot]) / DEPTH
            + longint'(velocity_now) / DEPTH;
      average_est = sum[VEL_W-1:0];
      velocity_history[history_slot] = velocity_now;
      history_slot = history_slot + 1'b1;
    end
    last_sample_pos = pos;
    return average_est;
  endfunction

  initial begin
    for (int i = 0; i < DEPTH; i++) velocity_history[i] = '0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) scale_est = cfg_ch.velocity_scale;
      if (in_ch.valid && in_ch.ready) begin
        predicted_velocity = predict_average(in_ch.action, in_ch.position);
        expected_velocities.push_back(row_typed ? row_velocity : predicted_velocity);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_velocities.size() == 0) begin
          $display("%0t unexpected velocity transaction: got %0d", $time, out_ch.velocity);
          mismatch_seen = 1'b1;
        end else begin
          if (out_ch.velocity !== expected_velocities[0]) begin
            $display("%0t velocity mismatch: expected %0d, got %0d",
                     $time, expected_velocities[0], out_ch.velocity);
            mismatch_seen = 1'b1;
          end
          void'(expected_velocities.pop_front());
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("position_velocity_moving_average_top_tb NOT OK");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance with valid held high
  task automatic send_item(input logic act, input logic signed [POS_W-1:0] pos,
                           input logic typed, input logic signed [VEL_W-1:0] vel);
    while (!no_idle && $urandom_range(99) < 16) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.position <= pos;
    row_typed      <= typed;
    row_velocity   <= vel;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Write the scale only once every pending average has come back
  task automatic write_scale(input logic [SCALE_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (expected_velocities.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.velocity_scale <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    stim_row_t               directed_rows [ROW_COUNT];
    logic [SCALE_W-1:0]      scale_steps [PHASE_COUNT];
    logic signed [POS_W-1:0] next_pos;
    logic signed [POS_W-1:0] last_pos;
    logic                    next_act;

    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.action          = ACT_SAMPLE;
    in_ch.position        = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.velocity_scale = SCALE_RST;
    row_typed             = 1'b0;
    row_velocity          = '0;
    no_idle               = 1'b0;
    mismatch_seen         = 1'b0;
    stall_cycles          = 0;

    // Reset scale of 1000 throughout the table
    directed_rows[0]  = '{ACT_SAMPLE, 32'sd0,           1'b1, 32'sd0};
    directed_rows[1]  = '{ACT_CLEAR,  32'sh7FFFFFFF,    1'b1, 32'sd0};
    directed_rows[2]  = '{ACT_SAMPLE, 32'sh80000000,    1'b1, -32'sd134217728};
    directed_rows[3]  = '{ACT_SAMPLE, 32'sh7FFFFFFF,    1'b0, 32'sd0};
    directed_rows[4]  = '{ACT_CLEAR,  32'sd0,           1'b1, 32'sd0};
    directed_rows[5]  = '{ACT_SAMPLE, -32'sd1,          1'b0, 32'sd0};
    directed_rows[6]  = '{ACT_SAMPLE, 32'sd0,           1'b0, 32'sd0};
    directed_rows[7]  = '{ACT_SAMPLE, 32'sd3,           1'b0, 32'sd0};
    directed_rows[8]  = '{ACT_SAMPLE, 32'sd10,          1'b0, 32'sd0};
    directed_rows[9]  = '{ACT_SAMPLE, 32'sd30,          1'b0, 32'sd0};
    directed_rows[10] = '{ACT_SAMPLE, 32'sd100,         1'b0, 32'sd0};
    directed_rows[11] = '{ACT_SAMPLE, 32'sd1000,        1'b0, 32'sd0};
    directed_rows[12] = '{ACT_SAMPLE, 32'sd1000000,     1'b0, 32'sd0};
    directed_rows[13] = '{ACT_SAMPLE, 32'sd999000,      1'b0, 32'sd0};
    directed_rows[14] = '{ACT_SAMPLE, -32'sd5,          1'b0, 32'sd0};
    directed_rows[15] = '{ACT_SAMPLE, -32'sd5,          1'b0, 32'sd0};
    directed_rows[16] = '{ACT_SAMPLE, 32'sd70000,       1'b0, 32'sd0};
    directed_rows[17] = '{ACT_SAMPLE, 32'sd70001,       1'b0, 32'sd0};
    directed_rows[18] = '{ACT_SAMPLE, 32'sh7FFFFFFF,    1'b0, 32'sd0};
    directed_rows[19] = '{ACT_SAMPLE, 32'sd7,           1'b0, 32'sd0};
    directed_rows[20] = '{ACT_SAMPLE, 32'sd8,           1'b0, 32'sd0};
    directed_rows[21] = '{ACT_SAMPLE, 32'sd12,          1'b0, 32'sd0};
    directed_rows[22] = '{ACT_SAMPLE, 32'sd4,           1'b0, 32'sd0};

    scale_steps[0] = 20'd1;
    scale_steps[1] = 20'd1000000;
    scale_steps[2] = 20'd0;
    scale_steps[3] = 20'hFFFFF;
    scale_steps[4] = SCALE_W'($urandom_range(1000000, 1));
    scale_steps[5] = SCALE_W'($urandom_range(1000000, 1));
    scale_steps[6] = SCALE_RST;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < ROW_COUNT; r++) begin
      send_item(directed_rows[r].action, directed_rows[r].position,
                directed_rows[r].typed, directed_rows[r].velocity);
    end
    last_pos = directed_rows[ROW_COUNT-1].position;

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      write_scale(scale_steps[phase]);
      no_idle = (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        next_act = ($urandom_range(24) == 0) ? ACT_CLEAR : ACT_SAMPLE;
        case ($urandom_range(9))
          0:       next_pos = $urandom();
          1:       next_pos = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
          2:       next_pos = last_pos + int'($urandom_range(2000000)) - 1000000;
          default: next_pos = last_pos + int'($urandom_range(4000)) - 2000;
        endcase
        send_item(next_act, next_pos, 1'b0, '0);
        last_pos = next_pos;
      end
    end
    no_idle = 1'b0;
    in_ch.valid <= 1'b0;

    while (expected_velocities.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (!mismatch_seen && expected_velocities.size() == 0) begin
      $display("position_velocity_moving_average_top_tb OK");
    end else begin
      $display("position_velocity_moving_average_top_tb NOT OK");
    end
    $finish;
  end

endmodule
